@@ src/dlws_pkg.sv @@
// Shared constants, codes and types for the double-ended list with search.
// No dependencies; every module of the block but dlws_ram imports this package.
package dlws_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMD_W  = 3;
    localparam int STS_W  = 2;
    localparam int POS_W  = 5;
    localparam int OUT_W  = 16;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [STS_W-1:0]  status_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_BACK   = 3'd3;
    localparam cmd_t CMD_SEARCH     = 3'd4;
    localparam cmd_t CMD_COUNT      = 3'd5;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_NOTFOUND = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic latch;   // capture an accepted word
        logic apply;   // execute a non-search command and load its result
        logic scan;    // advance the search by one entry
        logic finish;  // load the search result
    } dlws_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_scan;    // held command is a search on a non-empty list
        logic scan_done;  // search reached a match or the last entry
        logic out_free;   // output register can take a result this cycle
    } dlws_sts_t;

    // (base + off) wrapped round the ring; base < DEPTH and off <= DEPTH
    function automatic idx_t ring_add(idx_t base, cnt_t off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ src/double_ended_list_with_search.sv @@
// Top level of the double-ended list with search: controller plus datapath.
// Depends on dlws_pkg, dlws_ctrl, dlws_dp (and dlws_ram through dlws_dp).
//
// A bounded deque of DEPTH signed 32-bit entries kept in a ring RAM.
// Slave channel: s_tuser carries the command (push front, push back,
// pop front, pop back, search, count), s_tdata the value to insert or
// look for. Every accepted word returns exactly one result word on the
// master channel: status, 1-based match position and entry count.
// Push, pop, count and unused codes run in state EXEC after the accept and
// load their result there. A search walks the RAM one entry per cycle from
// the front, overlapping the registered read with the compare, in state
// SCAN, and loads its result from state DONE. One word is in work at a
// time; a new word is taken once the previous result has been loaded into
// the output register, even if that result still waits. Reset empties the
// list (front and count cleared); RAM contents are not cleared. When the
// receiver stalls, the result holds in the output register and the block
// stalls at most one further word behind it.
module double_ended_list_with_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [6:2] position,
                                   // [11:7] entry_count, [15:12] zero
);
    import dlws_pkg::*;

    dlws_cmd_t        cmd;
    dlws_sts_t        sts;
    status_t          out_status;
    logic [POS_W-1:0] out_position;
    logic [POS_W-1:0] out_count;

    dlws_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dlws_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_command  (s_tuser),
        .in_value    (s_tdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_position(out_position),
        .out_count   (out_count)
    );

    assign m_tdata = {(OUT_W - STS_W - 2 * POS_W)'(0), out_count, out_position, out_status};

endmodule

@@ src/dlws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/dlws_ctrl.sv @@
// Controller state machine for the double-ended list with search.
// Depends on dlws_pkg; drives the datapath through dlws_cmd_t.
module dlws_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  dlws_pkg::dlws_sts_t sts,
    output dlws_pkg::dlws_cmd_t cmd
);
    import dlws_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.is_scan)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/dlws_dp.sv @@
// Datapath: ring pointers, entry store, search scan and output register.
// Depends on dlws_pkg and dlws_ram; steered by dlws_ctrl.
module dlws_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dlws_pkg::dlws_cmd_t        cmd,
    output dlws_pkg::dlws_sts_t        sts,
    input  dlws_pkg::cmd_t             in_command,
    input  dlws_pkg::data_t            in_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output dlws_pkg::status_t          out_status,
    output logic [dlws_pkg::POS_W-1:0] out_position,
    output logic [dlws_pkg::POS_W-1:0] out_count
);
    import dlws_pkg::*;

    cmd_t    cmd_reg;
    data_t   val_reg;
    idx_t    front_reg, front_next;
    cnt_t    count_reg, count_next;
    cnt_t    rd_idx_reg;
    logic    pend_reg;
    logic    last_reg;
    cnt_t    cmp_pos_reg;
    logic    found_reg;
    cnt_t    pos_reg;
    logic    out_valid_reg;
    status_t out_status_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic [POS_W-1:0] out_count_reg;

    status_t exec_status;
    logic    full;
    logic    empty;
    logic    we;
    idx_t    waddr;
    idx_t    raddr;
    data_t   rdata;
    logic    match;
    logic    load;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign raddr = ring_add(front_reg, rd_idx_reg);
    assign match = (rdata == val_reg);

    dlws_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(val_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    // non-search command or search on an empty list: next pointers, store write, result status
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        exec_status = ST_OK;
        we          = 1'b0;
        waddr       = ring_add(front_reg, count_reg);
        unique case (cmd_reg)
            CMD_PUSH_FRONT:
            begin
                waddr = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
                if (full)
                begin
                    exec_status = ST_FULL;
                end
                else
                begin
                    front_next = waddr;
                    count_next = count_reg + 1'b1;
                    we         = cmd.apply;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    exec_status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    we         = cmd.apply;
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    exec_status = ST_EMPTY;
                end
                else
                begin
                    front_next = ring_add(front_reg, CNT_W'(1));
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    exec_status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_SEARCH:
            begin
                // only an empty list gets here; a non-empty one is scanned
                exec_status = ST_EMPTY;
            end
            default:
            begin
                exec_status = ST_OK;
            end
        endcase
    end

    assign load          = cmd.apply || cmd.finish;
    assign sts.is_scan   = (cmd_reg == CMD_SEARCH) && !empty;
    assign sts.scan_done = pend_reg && (match || last_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg <= in_command;
            val_reg <= in_value;
        end
        if (cmd.scan)
        begin
            // issue the next read while comparing the previous one
            cmp_pos_reg <= rd_idx_reg + 1'b1;
            last_reg    <= (rd_idx_reg + 1'b1 == count_reg);
            if (sts.scan_done)
            begin
                found_reg <= match;
                pos_reg   <= cmp_pos_reg;
            end
        end
        if (load)
        begin
            if (cmd.finish)
            begin
                out_status_reg <= found_reg ? ST_OK : ST_NOTFOUND;
                out_pos_reg    <= found_reg ? POS_W'(pos_reg) : '0;
                out_count_reg  <= POS_W'(count_reg);
            end
            else
            begin
                out_status_reg <= exec_status;
                out_pos_reg    <= '0;
                out_count_reg  <= POS_W'(count_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if (cmd.latch)
            begin
                rd_idx_reg <= '0;
                pend_reg   <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    pend_reg   <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_position = out_pos_reg;
    assign out_count    = out_count_reg;

endmodule
